[hdl/stpc_pkg.sv]
// Shared types and constants for the two-axis stepper position controller.
// No dependencies; every other file imports this package.
package stpc_pkg;

  localparam int POS_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [BYTE_W-1:0]   DEVICE_ID_RST   = 8'd1;
  localparam logic [PERIOD_W-1:0] HALF_PERIOD_RST = 16'd400;
  localparam logic [PERIOD_W-1:0] TIMER_MAX       = 16'hFFFF;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // reply codes
  localparam logic REPLY_CONFIRM = 1'b0;
  localparam logic REPLY_FAULT   = 1'b1;

  // command bytes
  localparam logic [BYTE_W-1:0] CMD_SET_A  = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_SET_B  = 8'd2;
  localparam logic [BYTE_W-1:0] CMD_LED    = 8'd3;
  localparam logic [BYTE_W-1:0] CMD_NOP_LO = 8'd4;
  localparam logic [BYTE_W-1:0] CMD_NOP_HI = 8'd10;

  // register index (paddr[2])
  localparam logic REG_DEVICE_ID   = 1'b0;
  localparam logic REG_HALF_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    PH_ADDR  = 2'd0,
    PH_VALUE = 2'd1,
    PH_CMD   = 2'd2
  } phase_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [POS_W-1:0] value;
  } tgt_cmd_t;

  typedef struct packed {
    logic valid;
    logic code;
  } reply_t;

  typedef struct packed {
    logic step;
    logic dir;
    logic enable_n;
  } axis_t;

endpackage

[hdl/stpc_in_if.sv]
// Input channel: received byte or microsecond tick, valid/ready handshake.
// Depends on stpc_pkg.
interface stpc_in_if import stpc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

[hdl/stpc_out_if.sv]
// Result channel: reply flags and motor/LED pin levels, valid/ready handshake.
// Depends on stpc_pkg only through the import.
interface stpc_out_if import stpc_pkg::*; ;
  logic valid;
  logic ready;
  logic reply_valid;
  logic reply_code;
  logic step_a;
  logic dir_a;
  logic enable_a_n;
  logic step_b;
  logic dir_b;
  logic enable_b_n;
  logic led_on;

  modport source (output valid, reply_valid, reply_code, step_a, dir_a, enable_a_n,
                  step_b, dir_b, enable_b_n, led_on, input ready);
  modport sink   (input valid, reply_valid, reply_code, step_a, dir_a, enable_a_n,
                  step_b, dir_b, enable_b_n, led_on, output ready);
endinterface

[hdl/two_axis_stepper_position_controller.sv]
// Top level of the two-axis stepper position controller.
// Depends on stpc_pkg, stpc_in_if, stpc_out_if, stpc_parser and stpc_axis.
//
//   channel   direction  handshake         payload
//   in_ch     sink       valid/ready       command, data_byte
//   out_ch    source     valid/ready       reply_valid, reply_code, A/B pins, led_on
//   cfg_*     APB slave  psel/penable      device_id @0x0, half_step_period @0x4
//
// Parser and axis state update at the accepting edge and the result lands
// in the output register, so one item per cycle unless the output stalls.
// The output register is the only stall point; a new item is accepted while
// the held result is taken in the same cycle.
// rst_n is synchronous, active low; no clearing pass is needed.
// Every item produces exactly one result.
module two_axis_stepper_position_controller import stpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  stpc_in_if.sink           in_ch,
  stpc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration registers
  logic [BYTE_W-1:0]   device_id_r;
  logic [PERIOD_W-1:0] half_period_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r   <= DEVICE_ID_RST;
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_wr) begin
      // register index is paddr[2]; byte offset bits are ignored
      unique case (cfg_paddr[2])
        REG_DEVICE_ID:   device_id_r   <= cfg_pwdata[BYTE_W-1:0];
        REG_HALF_PERIOD: half_period_r <= cfg_pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DEVICE_ID:   cfg_prdata = {{(APB_DW-BYTE_W){1'b0}}, device_id_r};
      REG_HALF_PERIOD: cfg_prdata = {{(APB_DW-PERIOD_W){1'b0}}, half_period_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // handshake: accept whenever the output register is free or being drained
  logic out_valid_r;
  logic accept, byte_en, tick_en;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign byte_en     = accept && (in_ch.command == KIND_BYTE);
  assign tick_en     = accept && (in_ch.command == KIND_TICK);

  reply_t   reply;
  tgt_cmd_t tgt_cmd;
  logic     led_nxt;
  axis_t    pins_a, pins_b;

  stpc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .data_byte (in_ch.data_byte),
    .device_id (device_id_r),
    .reply     (reply),
    .tgt_cmd   (tgt_cmd),
    .led_nxt   (led_nxt)
  );

  stpc_axis u_axis_a (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick_en),
    .tgt_wr      (tgt_cmd.wr_a),
    .tgt_val     (tgt_cmd.value),
    .half_period (half_period_r),
    .pins_nxt    (pins_a)
  );

  stpc_axis u_axis_b (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick_en),
    .tgt_wr      (tgt_cmd.wr_b),
    .tgt_val     (tgt_cmd.value),
    .half_period (half_period_r),
    .pins_nxt    (pins_b)
  );

  // result register: snapshot of reply and post-item pin levels
  reply_t reply_r;
  axis_t  pins_a_r, pins_b_r;
  logic   led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reply_r  <= reply;
      pins_a_r <= pins_a;
      pins_b_r <= pins_b;
      led_r    <= led_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reply_valid = reply_r.valid;
  assign out_ch.reply_code  = reply_r.code;
  assign out_ch.step_a      = pins_a_r.step;
  assign out_ch.dir_a       = pins_a_r.dir;
  assign out_ch.enable_a_n  = pins_a_r.enable_n;
  assign out_ch.step_b      = pins_b_r.step;
  assign out_ch.dir_b       = pins_b_r.dir;
  assign out_ch.enable_b_n  = pins_b_r.enable_n;
  assign out_ch.led_on      = led_r;

endmodule

[hdl/stpc_parser.sv]
// Three-byte command parser (address, value, command) with the LED flag.
// Depends on stpc_pkg.
module stpc_parser import stpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [BYTE_W-1:0] device_id,
  output reply_t            reply,
  output tgt_cmd_t          tgt_cmd,
  output logic              led_nxt
);

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  held_r;
  logic               led_r;

  always_comb begin
    phase_nxt = phase_r;
    if (byte_en) begin
      unique case (phase_r)
        PH_VALUE: phase_nxt = PH_CMD;
        PH_CMD:   phase_nxt = PH_ADDR;
        default:  phase_nxt = (data_byte == device_id) ? PH_VALUE : PH_ADDR;
      endcase
    end
  end

  always_comb begin
    reply         = '0;
    tgt_cmd.wr_a  = 1'b0;
    tgt_cmd.wr_b  = 1'b0;
    tgt_cmd.value = held_r;
    led_nxt       = led_r;
    if (byte_en && phase_r == PH_CMD) begin
      reply.valid = 1'b1;
      priority if (data_byte == CMD_SET_A) begin
        tgt_cmd.wr_a = 1'b1;
      end else if (data_byte == CMD_SET_B) begin
        tgt_cmd.wr_b = 1'b1;
      end else if (data_byte == CMD_LED) begin
        led_nxt = 1'b1;
      end else if (data_byte >= CMD_NOP_LO && data_byte <= CMD_NOP_HI) begin
        reply.code = REPLY_CONFIRM;
      end else begin
        reply.code = REPLY_FAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      held_r  <= '0;
      led_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      if (byte_en && phase_r == PH_VALUE) begin
        held_r <= data_byte;
      end
    end
  end

endmodule

[hdl/stpc_axis.sv]
// One step/direction generator: target, position, half-period timer, pin levels.
// Depends on stpc_pkg.
module stpc_axis import stpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic                tgt_wr,
  input  logic [POS_W-1:0]    tgt_val,
  input  logic [PERIOD_W-1:0] half_period,
  output axis_t               pins_nxt
);

  logic [POS_W-1:0]    target_r, pos_r, pos_nxt;
  logic [PERIOD_W-1:0] timer_r, timer_nxt, timer_inc;
  logic                step_r, step_nxt, dir_r, dir_nxt, en_r, en_nxt;
  logic                above;

  assign timer_inc = (timer_r != TIMER_MAX) ? timer_r + 1'b1 : timer_r;
  assign above     = pos_r > target_r;

  always_comb begin
    pos_nxt   = pos_r;
    timer_nxt = timer_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    en_nxt    = en_r;
    if (tick) begin
      timer_nxt = timer_inc;
      if (pos_r != target_r) begin
        dir_nxt = above;
        en_nxt  = 1'b1;
        if (timer_inc >= half_period) begin
          timer_nxt = '0;
          step_nxt  = ~step_r;
          // move on the rising step edge
          if (!step_r) begin
            pos_nxt = above ? pos_r - 1'b1 : pos_r + 1'b1;
          end
        end
      end else begin
        en_nxt = 1'b0;
      end
    end
  end

  assign pins_nxt.step     = step_nxt;
  assign pins_nxt.dir      = dir_nxt;
  assign pins_nxt.enable_n = ~en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      pos_r    <= '0;
      timer_r  <= '0;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
      en_r     <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      timer_r <= timer_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
      if (tgt_wr) begin
        target_r <= tgt_val;
      end
    end
  end

endmodule

[hdl/stpc_checker.sv]
// Port-level checks for the stepper controller, bound to the top level.
// Depends on stpc_pkg for reply codes.
module stpc_checker import stpc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_reply_valid,
  input logic out_reply_code,
  input logic out_led_on
);

  // an accepted item always yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted item produced no result");

  // the block never stalls the input while its result register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a fault code only comes with a reply
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reply_code == REPLY_FAULT) |-> out_reply_valid)
    else $error("fault code without reply");

  // once lit, the LED stays lit in every later result
  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_led_on) |=> (!out_valid || out_led_on))
    else $error("LED went dark");

endmodule

bind two_axis_stepper_position_controller stpc_checker u_stpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_reply_valid (out_ch.reply_valid),
  .out_reply_code  (out_ch.reply_code),
  .out_led_on      (out_ch.led_on)
);
